FILE: sv/assert_macros.svh
// Assertion macros shared by the frame reader RTL.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: sv/srfr_pkg.sv
// Shared types and constants of the SLIP response frame reader.
// Used by the decoder and the top level; depends on nothing.
package srfr_pkg;

    // SLIP special bytes.
    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    // Frame byte counter width and response header length.
    localparam int         COUNT_W    = 11;
    localparam logic [10:0] HEADER_LEN = 11'd8;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CHECK    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    // Item functions.
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_FRAME_LIMIT = 1'b0;
    localparam logic CFG_RESP_DIR    = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [10:0] FRAME_LIMIT_RST = 11'd1024;
    localparam logic [7:0]  RESP_DIR_RST    = 8'd1;

    // Result of one item, short of the byte read from the frame store.
    typedef struct packed {
        logic [1:0]  status;
        logic        resp_complete;
        logic [7:0]  command;
        logic [31:0] response_value;
        logic [9:0]  payload_length;
        logic        read_hit;
    } t_srfr_result;

endpackage

FILE: sv/srfr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on nothing.
module srfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/srfr_decoder.sv
// SLIP unframing, header shadow and response check of the frame reader.
// Depends on srfr_pkg and assert_macros.svh; drives the frame store ports.
`include "assert_macros.svh"

module srfr_decoder
    import srfr_pkg::*;
#(
    parameter int FRAME_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_func,
    input  logic [7:0]                     i_rx_byte,
    input  logic [9:0]                     i_read_index,
    input  logic [10:0]                    i_frame_limit,
    input  logic [7:0]                     i_response_direction,
    output t_srfr_result                   o_result,
    output logic                           o_wr_en,
    output logic [$clog2(FRAME_DEPTH)-1:0] o_wr_addr,
    output logic [7:0]                     o_wr_data,
    output logic                           o_rd_en,
    output logic [$clog2(FRAME_DEPTH)-1:0] o_rd_addr
);

    localparam int AW  = $clog2(FRAME_DEPTH);
    localparam int DW  = $clog2(FRAME_DEPTH + 1);
    localparam int KW  = (DW > COUNT_W) ? DW : COUNT_W;

    logic [10:0] r_byte_count, n_byte_count;
    logic        r_inside, n_inside;
    logic        r_escape, n_escape;
    logic [63:0] r_header, n_header;
    logic [10:0] r_last_plen, n_last_plen;

    logic        do_store;
    logic [7:0]  store_val;
    logic        overflow;
    logic [10:0] rd_sum;
    logic [15:0] hdr_len;
    logic [10:0] body_len;

    // Header length field and the byte count it must match.
    assign hdr_len  = {r_header[31:24], r_header[23:16]};
    assign body_len = r_byte_count - HEADER_LEN;
    assign overflow = (r_byte_count >= i_frame_limit) ||
                      (KW'(r_byte_count) >= KW'(FRAME_DEPTH));
    assign rd_sum   = {1'b0, i_read_index} + HEADER_LEN;

    // Next state, result and frame store access for the accepted item.
    always_comb begin
        n_byte_count = r_byte_count;
        n_inside     = r_inside;
        n_escape     = r_escape;
        n_header     = r_header;
        n_last_plen  = r_last_plen;
        o_result     = '0;
        do_store     = 1'b0;
        store_val    = i_rx_byte;
        o_wr_en      = 1'b0;
        o_wr_addr    = AW'(r_byte_count);
        o_wr_data    = store_val;
        o_rd_en      = 1'b0;
        o_rd_addr    = AW'(rd_sum);

        if (i_accept) begin
            if (i_func == FUNC_READ) begin
                if ({1'b0, i_read_index} >= r_last_plen) begin
                    o_result.status = ST_RANGE;
                end else begin
                    o_result.read_hit = 1'b1;
                    o_rd_en           = 1'b1;
                end
            end else if (i_rx_byte == SLIP_END) begin
                if (!r_inside) begin
                    // Opening delimiter starts a fresh frame.
                    n_inside     = 1'b1;
                    n_escape     = 1'b0;
                    n_byte_count = '0;
                    n_header     = '0;
                end else if (r_escape) begin
                    n_byte_count    = '0;
                    n_inside        = 1'b0;
                    n_escape        = 1'b0;
                    o_result.status = ST_CHECK;
                end else begin
                    // Closing delimiter: check the response header.
                    n_inside = 1'b0;
                    if (r_byte_count < HEADER_LEN ||
                        r_header[7:0] != i_response_direction ||
                        hdr_len != 16'(body_len)) begin
                        n_byte_count    = '0;
                        n_escape        = 1'b0;
                        o_result.status = ST_CHECK;
                    end else begin
                        o_result.resp_complete  = 1'b1;
                        o_result.command        = r_header[15:8];
                        o_result.response_value = r_header[63:32];
                        o_result.payload_length = body_len[9:0];
                        n_last_plen             = body_len;
                    end
                end
            end else if (r_inside) begin
                if (r_escape) begin
                    n_escape = 1'b0;
                    if (i_rx_byte == SLIP_ESC_END) begin
                        do_store  = 1'b1;
                        store_val = SLIP_END;
                    end else if (i_rx_byte == SLIP_ESC_ESC) begin
                        do_store  = 1'b1;
                        store_val = SLIP_ESC;
                    end else begin
                        n_byte_count    = '0;
                        n_inside        = 1'b0;
                        o_result.status = ST_CHECK;
                    end
                end else if (i_rx_byte == SLIP_ESC) begin
                    n_escape = 1'b1;
                end else begin
                    do_store = 1'b1;
                end
            end
        end

        // Store one unescaped byte, or drop the frame when it is full.
        o_wr_data = store_val;
        if (do_store) begin
            if (overflow) begin
                n_byte_count    = '0;
                n_inside        = 1'b0;
                n_escape        = 1'b0;
                o_result.status = ST_OVERFLOW;
            end else begin
                o_wr_en      = 1'b1;
                n_byte_count = r_byte_count + 11'd1;
                for (int k = 0; k < 8; k++) begin
                    if (r_byte_count < HEADER_LEN && r_byte_count[2:0] == 3'(k)) begin
                        n_header[k*8 +: 8] = store_val;
                    end
                end
            end
        end
    end

    // Decoder state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_inside     <= 1'b0;
            r_escape     <= 1'b0;
            r_header     <= '0;
            r_last_plen  <= '0;
        end else begin
            r_byte_count <= n_byte_count;
            r_inside     <= n_inside;
            r_escape     <= n_escape;
            r_header     <= n_header;
            r_last_plen  <= n_last_plen;
        end
    end

    // An escape is only ever pending inside a frame.
    `ASSERT_PROP(a_escape_in_frame, i_clk, i_rst_n, r_escape |-> r_inside)
    // The byte count never runs past the frame store.
    `ASSERT_PROP(a_count_bound, i_clk, i_rst_n, KW'(r_byte_count) <= KW'(FRAME_DEPTH))
    // A completed response closes the frame.
    `ASSERT_PROP(a_close_frame, i_clk, i_rst_n,
        (i_accept && o_result.resp_complete) |=> !r_inside)

endmodule

FILE: sv/slip_response_frame_reader.sv
// Top level of the SLIP response frame reader: configuration, frame store,
// decoder and output stage. Depends on srfr_pkg, srfr_ram, srfr_decoder.
`include "assert_macros.svh"

// The block takes one beat per clock cycle, push or read, while the output is
// not stalled, and returns one result beat for each through the first stage and
// output register. The rate is set by the frame store: each beat makes at most one write
// or one read of its single write port and single registered read port, and
// all framing and header state sits in registers updated in the same cycle.
// A read returns the payload byte the store holds at that moment, so a frame
// received after the last good response may already have replaced it.
module slip_response_frame_reader
    import srfr_pkg::*;
#(
    parameter int FRAME_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [7:0]  i_rx_byte,
    input  logic [9:0]  i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_resp_complete,
    output logic [7:0]  o_command,
    output logic [31:0] o_response_value,
    output logic [9:0]  o_payload_length,
    output logic [7:0]  o_read_data
);

    localparam int AW = $clog2(FRAME_DEPTH);

    logic [10:0]  r_frame_limit;
    logic [7:0]   r_resp_dir;
    logic         accept_in;
    logic         s1_move;
    t_srfr_result dec_result;
    logic         wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]   wr_data;
    logic         rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]   rd_data;
    logic         r_s1_valid;
    t_srfr_result r_s1;
    logic         r_out_valid;
    t_srfr_result r_out;
    logic [7:0]   r_out_rdata;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= FRAME_LIMIT_RST;
            r_resp_dir    <= RESP_DIR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_LIMIT: r_frame_limit <= i_cfg_data;
                CFG_RESP_DIR:    r_resp_dir    <= i_cfg_data[7:0];
                default:         r_frame_limit <= r_frame_limit;
            endcase
        end
    end

    // Handshake between the input, the first stage and the output register.
    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign accept_in  = i_in_valid && o_in_ready;

    srfr_decoder #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_decoder (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_accept             (accept_in),
        .i_func               (i_func),
        .i_rx_byte            (i_rx_byte),
        .i_read_index         (i_read_index),
        .i_frame_limit        (r_frame_limit),
        .i_response_direction (r_resp_dir),
        .o_result             (dec_result),
        .o_wr_en              (wr_en),
        .o_wr_addr            (wr_addr),
        .o_wr_data            (wr_data),
        .o_rd_en              (rd_en),
        .o_rd_addr            (rd_addr)
    );

    srfr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_DEPTH)
    ) u_frame_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // First stage waits for the frame store read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept_in || (r_s1_valid && !s1_move);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1 <= dec_result;
        end
    end

    // Output register; the read byte is merged in here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out       <= r_s1;
            r_out_rdata <= r_s1.read_hit ? rd_data : 8'd0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_resp_complete  = r_out.resp_complete;
    assign o_command        = r_out.command;
    assign o_response_value = r_out.response_value;
    assign o_payload_length = r_out.payload_length;
    assign o_read_data      = r_out_rdata;

    // A completed response always reports success.
    `ASSERT_PROP(a_ready_ok, i_clk, i_rst_n,
        (o_out_valid && o_resp_complete) |-> (o_status == ST_OK))
    // Read data only comes with a successful read beat.
    `ASSERT_PROP(a_rdata_ok, i_clk, i_rst_n,
        (o_out_valid && (o_read_data != 8'd0)) |-> (o_status == ST_OK && !o_resp_complete))
    // A stalled output keeps the first stage occupied.
    `ASSERT_PROP(a_s1_hold, i_clk, i_rst_n,
        (r_s1_valid && r_out_valid && !i_out_ready) |=> r_s1_valid)

endmodule
